/* design/dct2o_pkg.sv */
`timescale 1ns / 1ps
package dct2o_pkg;

  localparam int FRAME_LEN = 64;
  localparam int LG        = $clog2(FRAME_LEN);
  localparam int IW        = LG;
  localparam int STEP      = 64 / FRAME_LEN;
  localparam int SMP_W     = 16;
  localparam int COS_W     = 17;
  localparam int PROD_W    = SMP_W + COS_W;
  localparam int ACC_W     = PROD_W + 6;
  localparam int COEF_W    = 23;
  localparam int KIDX_W    = 6;
  localparam int SQRT_HALF = 23170;
  localparam int MUL_W     = ACC_W + 15;

  // scaling for dc (h0) and for the other bins (h1)
  localparam int H0  = LG;
  localparam int H1  = LG - 1;
  localparam int SH0 = (H0 % 2 == 1) ? 26 + (H0 - 1) / 2 : 11 + H0 / 2;
  localparam int SH1 = (H1 % 2 == 1) ? 26 + (H1 - 1) / 2 : 11 + H1 / 2;
  localparam bit ODD0 = (H0 % 2 == 1);
  localparam bit ODD1 = (H1 % 2 == 1);

  typedef logic [64:0][15:0] cos_tab_t;

  // restoring long division, only used while building the table
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned q, rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // quarter-wave cosine in q15, taylor series in q30
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    longint unsigned x, x2, term, dv;
    longint sum;
    for (int j = 0; j <= 64; j++) begin
      x    = (64'd3373259426 * 64'(j) + 64'd64) >> 7;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int n = 1; n <= 12; n++) begin
        dv   = 64'((2 * n - 1) * (2 * n));
        term = div_u64((term * x2) >> 30, dv);
        if (n[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 64'd16384) >>> 15;
      if (sum > 32767) sum = 32767;
      tab[j] = 16'(sum);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  function automatic logic signed [COS_W-1:0] cos_full(input logic [7:0] m);
    logic signed [COS_W-1:0] r;
    if (m <= 8'd64) r = $signed({1'b0, COS_TAB[m[6:0]]});
    else if (m <= 8'd128) r = -$signed({1'b0, COS_TAB[7'(8'd128 - m)]});
    else if (m <= 8'd192) r = -$signed({1'b0, COS_TAB[7'(m - 8'd128)]});
    else r = $signed({1'b0, COS_TAB[7'(9'd256 - {1'b0, m})]});
    return r;
  endfunction

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [IW-1:0]           k;
  } acc_word_t;

  typedef enum logic {ST_IDLE, ST_RUN} seq_state_t;

endpackage

/* design/dct2o_front.sv */
`timescale 1ns / 1ps
module dct2o_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [15:0]          sample,
  output logic                        busy,
  output logic                        push,
  output dct2o_pkg::acc_word_t        push_word
);
  import dct2o_pkg::*;

  logic signed [SMP_W-1:0] mem [FRAME_LEN];
  seq_state_t state, state_next;
  logic [IW-1:0] load_count, i, k;
  logic [7:0] m, base;
  logic accept, wrap_i, last_k;

  logic v1, first1, last1, v2, first2, last2, v3, first3, last3;
  logic [IW-1:0] k1, k2, k3, kout;
  logic [7:0] m1;
  logic signed [SMP_W-1:0] smp1, smp2;
  logic signed [COS_W-1:0] cos2;
  logic signed [PROD_W-1:0] prod3;
  logic signed [ACC_W-1:0] acc, acc_sum;

  assign accept = start && !busy;
  assign busy   = (state == ST_RUN);
  assign wrap_i = (i == IW'(FRAME_LEN - 1));
  assign last_k = (k == IW'(FRAME_LEN - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && load_count == IW'(FRAME_LEN - 1)) state_next = ST_RUN;
      ST_RUN:  if (wrap_i && last_k) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) mem[load_count] <= sample;
    smp1 <= mem[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      load_count <= '0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; push <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) load_count <= load_count + 1'b1;
      v1   <= busy;
      v2   <= v1;
      v3   <= v2;
      push <= v3 && last3;
    end
  end

  // angle walks by 2*k*step per sample; base by step per bin
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      i <= '0; k <= '0; m <= '0; base <= '0;
    end else begin
      if (wrap_i) begin
        i    <= '0;
        k    <= k + 1'b1;
        base <= base + 8'(STEP);
        m    <= base + 8'(STEP);
      end else begin
        i <= i + 1'b1;
        m <= m + {base[6:0], 1'b0};
      end
    end
    first1 <= (i == '0); last1 <= wrap_i; k1 <= k; m1 <= m;
    first2 <= first1; last2 <= last1; k2 <= k1;
    smp2 <= smp1; cos2 <= cos_full(m1);
    first3 <= first2; last3 <= last2; k3 <= k2;
    prod3 <= smp2 * cos2;
    if (v3) acc <= acc_sum;
    if (v3 && last3) kout <= k3;
  end

  assign acc_sum = first3 ? ACC_W'(prod3) : acc + ACC_W'(prod3);
  assign push_word = '{acc: acc, k: kout};

endmodule

/* design/dct2o_fifo.sv */
`timescale 1ns / 1ps
module dct2o_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dct2o_pkg::acc_word_t wdata,
  input  logic                 pop,
  output logic                 empty,
  output dct2o_pkg::acc_word_t rdata
);
  import dct2o_pkg::*;

  acc_word_t q [4];
  logic [1:0] wp, rp;
  logic [2:0] count;
  logic do_pop;

  assign empty  = (count == 3'd0);
  assign do_pop = pop && !empty;
  assign rdata  = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      count <= count + 3'(push) - 3'(do_pop);
    end
  end

endmodule

/* design/dct2o_back.sv */
`timescale 1ns / 1ps
module dct2o_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  dct2o_pkg::acc_word_t        word,
  output logic                        pop,
  output logic                        valid,
  output logic signed [22:0]          coefficient,
  output logic [5:0]                  coef_index,
  output logic                        last_of_frame
);
  import dct2o_pkg::*;

  logic v1;
  logic neg1, dc1;
  logic [IW-1:0] k1;
  logic [MUL_W-1:0] prod1;
  logic [ACC_W-1:0] mag;
  logic odd;
  logic [MUL_W:0] r0, r1, r;
  logic signed [COEF_W-1:0] sat;

  assign pop = !empty;
  assign mag = word.acc[ACC_W-1] ? ACC_W'(-word.acc) : ACC_W'(word.acc);
  assign odd = (word.k == '0) ? ODD0 : ODD1;

  assign r0 = ({1'b0, prod1} + ((MUL_W+1)'(1) << (SH0 - 1))) >> SH0;
  assign r1 = ({1'b0, prod1} + ((MUL_W+1)'(1) << (SH1 - 1))) >> SH1;
  assign r  = dc1 ? r0 : r1;

  always_comb begin
    if (neg1) sat = (r >= (MUL_W+1)'(1 << 22)) ? -COEF_W'(1 << 22)
                                                : -$signed(COEF_W'(r));
    else sat = (r > (MUL_W+1)'((1 << 22) - 1)) ? COEF_W'((1 << 22) - 1)
                                                : COEF_W'(r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; valid <= 1'b0;
    end else begin
      v1 <= pop;
      valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    neg1  <= word.acc[ACC_W-1];
    dc1   <= (word.k == '0);
    k1    <= word.k;
    prod1 <= odd ? MUL_W'(mag * 15'(SQRT_HALF)) : MUL_W'(mag);
    coefficient   <= sat;
    coef_index    <= KIDX_W'(k1);
    last_of_frame <= (k1 == IW'(FRAME_LEN - 1));
  end

endmodule

/* design/dct2_orthonormal.sv */
`timescale 1ns / 1ps
// channel   | ports                                       | handshake
// ----------+---------------------------------------------+--------------------------
// input     | sample                                      | start high, busy low
// result    | coefficient, coef_index, last_of_frame      | valid, one cycle, no stall
//
// a sample is written each time start is high and busy is low; after the last sample of a
// frame the single multiply-accumulate unit walks every sample for every bin while
// busy is high, and no new samples are taken until it is done.
// each bin's sum is pushed into a four-entry fifo and comes out of the back end as one coefficient.
// rst is synchronous and clears the sample count, the sequencer state, the fifo pointers and the valid pipeline.
module dct2_orthonormal (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] sample,
  output logic               busy,
  output logic               valid,
  output logic signed [22:0] coefficient,
  output logic [5:0]         coef_index,
  output logic               last_of_frame
);
  import dct2o_pkg::*;

  logic push, pop, empty;
  acc_word_t push_word, head;

  dct2o_front u_front (
    .clk(clk), .rst(rst), .start(start), .sample(sample), .busy(busy),
    .push(push), .push_word(push_word)
  );

  dct2o_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(push_word),
    .pop(pop), .empty(empty), .rdata(head)
  );

  dct2o_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .word(head), .pop(pop),
    .valid(valid), .coefficient(coefficient), .coef_index(coef_index),
    .last_of_frame(last_of_frame)
  );

endmodule
